// File: hdl/bspl_pkg.sv
// ----------------------------------------------------------------------------
// bspl_pkg
// Shared types and constants for the BSP point-to-leaf locator.
// ----------------------------------------------------------------------------
package bspl_pkg;

    typedef enum logic [1:0] {
        ACT_WR_NODE  = 2'd0,
        ACT_WR_PLANE = 2'd1,
        ACT_LOCATE   = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_WRITE = 2'd0,
        STAT_FOUND = 2'd1,
        STAT_BAD   = 2'd2,
        STAT_LIMIT = 2'd3
    } status_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_NODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAF_COUNT = 2'd2;

    // 3 products of 40 bits plus a 38-bit offset term
    localparam int ACC_W = 43;

    typedef struct packed {
        action_t            action;
        logic [11:0]        slot;
        logic [11:0]        node_plane;
        logic signed [15:0] front_child;
        logic signed [15:0] back_child;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [23:0] plane_offset;
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic signed [23:0] point_z;
    } cmd_word_t;

    typedef struct packed {
        status_t     status;
        logic [14:0] leaf_index;
    } res_word_t;

    typedef struct packed {
        logic [11:0]        plane;
        logic signed [15:0] front;
        logic signed [15:0] back;
    } node_ent_t;

    typedef struct packed {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic signed [23:0] offset;
    } plane_ent_t;

    typedef struct packed {
        logic mul_en;
        logic acc_clr;
        logic acc_en;
    } mac_ctrl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NODE_RD,
        S_PLANE_RD,
        S_MUL_X,
        S_MUL_Y,
        S_MUL_Z,
        S_ACC,
        S_DECIDE,
        S_FINISH
    } state_t;

endpackage

// File: hdl/bspl_mac.sv
// ----------------------------------------------------------------------------
// bspl_mac
// Shared multiply-accumulate unit: one 16x24 product per cycle while enabled,
// registered, summed into a wide accumulator preloaded with -offset * 2^14.
// ----------------------------------------------------------------------------
module bspl_mac
    import bspl_pkg::*;
(
    input  logic               clk,
    input  mac_ctrl_t          ctrl,
    input  logic signed [15:0] op_n,
    input  logic signed [23:0] op_p,
    input  logic signed [23:0] offset,
    output logic               acc_neg
);

    logic signed [39:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= op_n * op_p;
        end
        if (ctrl.acc_clr)
        begin
            // start from -offset * 2^14
            acc_reg <= -$signed({{5{offset[23]}}, offset, 14'b0});
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign acc_neg = acc_reg[ACC_W-1];

endmodule

// File: hdl/bsp_point_leaf_locate_core.sv
// Writes, unused actions, a bad root and a bad plane go on to the finish state,
//   which loads the result when the result register is free; a locate walks its nodes first.
// Each node: node read, plane read, three passes through the shared 16x24
//   multiplier, one accumulate and the branch decision.
// One word at a time: a new word is taken only back in idle; a stalled result holds it off.
// Reset clears config registers, state and result valid; tables hold garbage until written.
// ----------------------------------------------------------------------------
// bsp_point_leaf_locate_core
// BSP tree walker: node and plane tables, fixed-point plane test, leaf result.
// ----------------------------------------------------------------------------
module bsp_point_leaf_locate_core
    import bspl_pkg::*;
#(
    parameter int NODE_SLOTS  = 4096,
    parameter int PLANE_SLOTS = 4096,
    parameter int WALK_LIMIT  = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  cmd_word_t             cmd,
    output logic                  res_valid,
    input  logic                  res_ready,
    output res_word_t             res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NODE_AW  = $clog2(NODE_SLOTS);
    localparam int PLANE_AW = $clog2(PLANE_SLOTS);
    localparam int STEP_W   = $clog2(WALK_LIMIT);
    localparam logic [16:0]       NODE_LIM   = 17'(NODE_SLOTS);
    localparam logic [16:0]       PLANE_LIM  = 17'(PLANE_SLOTS);
    localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(WALK_LIMIT - 1);

    // tables
    node_ent_t  node_mem  [NODE_SLOTS];
    plane_ent_t plane_mem [PLANE_SLOTS];
    node_ent_t  node_q;
    plane_ent_t plane_q;

    // config
    logic signed [12:0] root_node_reg;
    logic [12:0]        node_count_reg;
    logic [15:0]        leaf_count_reg;

    // control
    state_t              state_reg,  state_next;
    logic [NODE_AW-1:0]  cur_reg,    cur_next;
    logic [STEP_W-1:0]   step_reg,   step_next;
    logic signed [23:0]  pt_x_reg,   pt_x_next;
    logic signed [23:0]  pt_y_reg,   pt_y_next;
    logic signed [23:0]  pt_z_reg,   pt_z_next;
    res_word_t           pend_reg,   pend_next;
    res_word_t           res_reg;
    logic                res_valid_reg, res_valid_next;
    logic                res_load;

    logic               node_we;
    logic               plane_we;
    mac_ctrl_t          mac_ctrl;
    logic signed [15:0] op_n;
    logic signed [23:0] op_p;
    logic               acc_neg;

    logic               slot_node_ok;
    logic               slot_plane_ok;
    logic               root_ok;
    logic               plane_ok;
    logic signed [15:0] child;
    logic               child_ok;
    logic               leaf_ok;

    node_ent_t  node_wdata;
    plane_ent_t plane_wdata;

    assign node_wdata.plane  = cmd.node_plane;
    assign node_wdata.front  = cmd.front_child;
    assign node_wdata.back   = cmd.back_child;
    assign plane_wdata.nx    = cmd.normal_x;
    assign plane_wdata.ny    = cmd.normal_y;
    assign plane_wdata.nz    = cmd.normal_z;
    assign plane_wdata.offset = cmd.plane_offset;

    assign slot_node_ok  = {5'b0, cmd.slot} < NODE_LIM;
    assign slot_plane_ok = {5'b0, cmd.slot} < PLANE_LIM;
    assign root_ok       = !root_node_reg[12]
                           && ({4'b0, root_node_reg} < {4'b0, node_count_reg})
                           && ({4'b0, root_node_reg} < NODE_LIM);
    assign plane_ok      = {5'b0, node_q.plane} < PLANE_LIM;

    assign child    = acc_neg ? node_q.back : node_q.front;
    assign child_ok = ({1'b0, child} < {4'b0, node_count_reg})
                      && ({1'b0, child} < NODE_LIM);
    // leaf = -1 - child = ~child for a negative child
    assign leaf_ok  = {1'b0, ~child[14:0]} < leaf_count_reg;

    // node table
    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[NODE_AW'(cmd.slot)] <= node_wdata;
        end
        if (state_reg == S_NODE_RD)
        begin
            node_q <= node_mem[cur_reg];
        end
    end

    // plane table
    always_ff @(posedge clk)
    begin
        if (plane_we)
        begin
            plane_mem[PLANE_AW'(cmd.slot)] <= plane_wdata;
        end
        if (state_reg == S_PLANE_RD)
        begin
            plane_q <= plane_mem[PLANE_AW'(node_q.plane)];
        end
    end

    bspl_mac u_mac (
        .clk     (clk),
        .ctrl    (mac_ctrl),
        .op_n    (op_n),
        .op_p    (op_p),
        .offset  (plane_q.offset),
        .acc_neg (acc_neg)
    );

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_node_reg  <= '0;
            node_count_reg <= '0;
            leaf_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROOT_NODE:  root_node_reg  <= cfg_data[12:0];
                CFG_NODE_COUNT: node_count_reg <= cfg_data[12:0];
                CFG_LEAF_COUNT: leaf_count_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        step_reg <= step_next;
        pt_x_reg <= pt_x_next;
        pt_y_reg <= pt_y_next;
        pt_z_reg <= pt_z_next;
        pend_reg <= pend_next;
        if (res_load)
        begin
            res_reg <= pend_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        step_next  = step_reg;
        pt_x_next  = pt_x_reg;
        pt_y_next  = pt_y_reg;
        pt_z_next  = pt_z_reg;
        pend_next  = pend_reg;
        node_we    = 1'b0;
        plane_we   = 1'b0;
        mac_ctrl   = '0;
        op_n       = plane_q.nx;
        op_p       = pt_x_reg;
        res_load   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    pend_next.status     = STAT_BAD;
                    pend_next.leaf_index = '0;
                    state_next           = S_FINISH;
                    unique case (cmd.action)
                        ACT_WR_NODE:
                        begin
                            node_we          = slot_node_ok;
                            pend_next.status = STAT_WRITE;
                        end
                        ACT_WR_PLANE:
                        begin
                            plane_we         = slot_plane_ok;
                            pend_next.status = STAT_WRITE;
                        end
                        ACT_LOCATE:
                        begin
                            pt_x_next = cmd.point_x;
                            pt_y_next = cmd.point_y;
                            pt_z_next = cmd.point_z;
                            cur_next  = NODE_AW'(root_node_reg);
                            step_next = '0;
                            if (root_ok)
                            begin
                                state_next = S_NODE_RD;
                            end
                        end
                        default:
                        begin
                            pend_next.status = STAT_BAD;
                        end
                    endcase
                end
            end
            S_NODE_RD:
            begin
                state_next = S_PLANE_RD;
            end
            S_PLANE_RD:
            begin
                state_next = plane_ok ? S_MUL_X : S_FINISH;
            end
            S_MUL_X:
            begin
                mac_ctrl.mul_en  = 1'b1;
                mac_ctrl.acc_clr = 1'b1;
                state_next       = S_MUL_Y;
            end
            S_MUL_Y:
            begin
                op_n            = plane_q.ny;
                op_p            = pt_y_reg;
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.acc_en = 1'b1;
                state_next      = S_MUL_Z;
            end
            S_MUL_Z:
            begin
                op_n            = plane_q.nz;
                op_p            = pt_z_reg;
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.acc_en = 1'b1;
                state_next      = S_ACC;
            end
            S_ACC:
            begin
                mac_ctrl.acc_en = 1'b1;
                state_next      = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_FINISH;
                if (child[15])
                begin
                    if (leaf_ok)
                    begin
                        pend_next.status     = STAT_FOUND;
                        pend_next.leaf_index = ~child[14:0];
                    end
                end
                else if (child_ok)
                begin
                    if (step_reg == STEP_LAST)
                    begin
                        pend_next.status = STAT_LIMIT;
                    end
                    else
                    begin
                        cur_next   = NODE_AW'(child);
                        step_next  = step_reg + 1'b1;
                        state_next = S_NODE_RD;
                    end
                end
            end
            S_FINISH:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: hdl/bspl_checker.sv
// ----------------------------------------------------------------------------
// bspl_checker
// Port-level checks for the BSP locator, bound to the top level.
// ----------------------------------------------------------------------------
module bspl_checker
    import bspl_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cmd_valid,
    input logic      cmd_ready,
    input logic      res_valid,
    input logic      res_ready,
    input res_word_t res
);

    // a stalled result word stays up
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result word dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res))
        else $error("result word changed while stalled");

    // leaf index only carries data on a found leaf
    a_leaf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status != STAT_FOUND |-> res.leaf_index == '0)
        else $error("leaf index nonzero without a found leaf");

    // one word at a time: busy right after taking a command
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while a word is in flight");

endmodule

bind bsp_point_leaf_locate_core bspl_checker u_bspl_checker (.*);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the BSP locator: fills the node and plane tables,
// walks points through the tree and checks every status and leaf word.
// ----------------------------------------------------------------------------
module testbench;
    import bspl_pkg::*;

    localparam int NODE_SLOTS  = 4096;
    localparam int PLANE_SLOTS = 4096;
    localparam int WALK_LIMIT  = 256;
    localparam int ITEM_GOAL   = 1700;
    localparam longint CYCLE_LIMIT = 20_000_000;

    // index past the last register, must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cmd_valid = 1'b0;
    logic                  cmd_ready;
    cmd_word_t             cmd = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    res_word_t             res;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int     idle_pct = 0;
    int     stall_pct = 0;
    int     span_nodes = 16;
    int     span_planes = 16;
    int     words_sent = 0;
    longint cycle_count = 0;

    bsp_point_leaf_locate_core #(
        .NODE_SLOTS  (NODE_SLOTS),
        .PLANE_SLOTS (PLANE_SLOTS),
        .WALK_LIMIT  (WALK_LIMIT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow tables, registers and the queue of leaf words still owed.
    class bsp_walk_tracker;
        node_ent_t  nodes [NODE_SLOTS];
        plane_ent_t planes [PLANE_SLOTS];
        bit         node_set [NODE_SLOTS];
        bit         plane_set [PLANE_SLOTS];
        int         root_idx;
        int         node_lim;
        int         leaf_lim;
        res_word_t  words_due [$];
        int         fails;

        function new();
            root_idx = 0;
            node_lim = 0;
            leaf_lim = 0;
            fails = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_ROOT_NODE:  root_idx = int'($signed(val[12:0]));
                CFG_NODE_COUNT: node_lim = int'(val[12:0]);
                CFG_LEAF_COUNT: leaf_lim = int'(val);
                default: ;
            endcase
        endfunction

        function bit node_ok(int idx);
            return idx >= 0 && idx < node_lim && idx < NODE_SLOTS;
        endfunction

        // Walks the tree; an entry that was never written is reported, not read.
        function status_t trace_leaf(input logic signed [23:0] px, py, pz,
                                     output logic [14:0] leaf,
                                     output int miss_node, output int miss_plane);
            int         cur;
            int         child;
            longint     side;
            node_ent_t  nd;
            plane_ent_t pl;
            leaf = '0;
            miss_node = -1;
            miss_plane = -1;
            cur = root_idx;
            if (!node_ok(cur))
                return STAT_BAD;
            for (int step = 0; step < WALK_LIMIT; step++)
            begin
                if (!node_set[cur])
                begin
                    miss_node = cur;
                    return STAT_BAD;
                end
                nd = nodes[cur];
                // 12-bit plane field always falls inside the plane table
                if (!plane_set[nd.plane])
                begin
                    miss_plane = nd.plane;
                    return STAT_BAD;
                end
                pl = planes[nd.plane];
                side = longint'(pl.nx) * longint'(px) + longint'(pl.ny) * longint'(py)
                     + longint'(pl.nz) * longint'(pz) - longint'(pl.offset) * 16384;
                child = (side >= 0) ? nd.front : nd.back;
                if (child < 0)
                begin
                    if (-1 - child >= leaf_lim)
                        return STAT_BAD;
                    leaf = 15'(-1 - child);
                    return STAT_FOUND;
                end
                if (!node_ok(child))
                    return STAT_BAD;
                cur = child;
            end
            return STAT_LIMIT;
        endfunction

        function void take_cmd(cmd_word_t w);
            res_word_t   r;
            status_t     st;
            logic [14:0] lf;
            int          mn;
            int          mp;
            r.status = STAT_WRITE;
            r.leaf_index = '0;
            // 12-bit slot never exceeds either table
            case (w.action)
                ACT_WR_NODE:
                begin
                    nodes[w.slot] = '{w.node_plane, w.front_child, w.back_child};
                    node_set[w.slot] = 1'b1;
                end
                ACT_WR_PLANE:
                begin
                    planes[w.slot] = '{w.normal_x, w.normal_y, w.normal_z, w.plane_offset};
                    plane_set[w.slot] = 1'b1;
                end
                ACT_LOCATE:
                begin
                    st = trace_leaf(w.point_x, w.point_y, w.point_z, lf, mn, mp);
                    r.status = st;
                    if (st == STAT_FOUND)
                        r.leaf_index = lf;
                end
                default: r.status = STAT_BAD;
            endcase
            words_due.push_back(r);
        endfunction

        function void match_res(res_word_t got);
            res_word_t want;
            if (words_due.size() == 0)
            begin
                fails++;
                $error("unexpected word: status %0d leaf_index %0d",
                       got.status, got.leaf_index);
                return;
            end
            want = words_due.pop_front();
            if (got.status !== want.status)
            begin
                fails++;
                $error("status: expected %0d actual %0d", want.status, got.status);
            end
            if (got.leaf_index !== want.leaf_index)
            begin
                fails++;
                $error("leaf_index: expected %0d actual %0d",
                       want.leaf_index, got.leaf_index);
            end
        endfunction

        function int outstanding();
            return words_due.size();
        endfunction
    endclass

    bsp_walk_tracker tracker;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("bsp_point_leaf_locate_core: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && res_ready)
                tracker.match_res(res);
            res_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic cmd_word_t noise_word();
        logic [223:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return cmd_word_t'(raw[$bits(cmd_word_t)-1:0]);
    endfunction

    function automatic cmd_word_t blank_word(action_t a);
        cmd_word_t w;
        w = '0;
        w.action = a;
        return w;
    endfunction

    function automatic logic signed [15:0] pick_child(int slot);
        int r;
        int leaf;
        int lmax;
        r = $urandom_range(99);
        lmax = (tracker.leaf_lim + 2 > 32767) ? 32767 : tracker.leaf_lim + 2;
        if (r < 40 || (r < 94 && slot + 1 >= span_nodes))
        begin
            leaf = ($urandom_range(9) == 0) ? $urandom_range(32767) : $urandom_range(lmax);
            return 16'(-1 - leaf);
        end
        if (r < 94)
            return 16'($urandom_range(span_nodes - 1, slot + 1));
        // back edges can close a loop
        if (r < 97)
            return 16'($urandom_range(span_nodes - 1));
        return 16'($urandom_range(32767));
    endfunction

    function automatic cmd_word_t node_word(int slot);
        cmd_word_t w;
        w = noise_word();
        w.action = ACT_WR_NODE;
        w.slot = 12'(slot);
        if ($urandom_range(9) != 0)
            w.node_plane = 12'($urandom_range(span_planes - 1));
        w.front_child = pick_child(slot);
        w.back_child = pick_child(slot);
        return w;
    endfunction

    function automatic cmd_word_t plane_word(int slot);
        cmd_word_t          w;
        logic signed [15:0] unit;
        w = noise_word();
        w.action = ACT_WR_PLANE;
        w.slot = 12'(slot);
        if ($urandom_range(9) < 3)
        begin
            // axis-aligned plane near the origin
            unit = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            w.normal_x = '0;
            w.normal_y = '0;
            w.normal_z = '0;
            case ($urandom_range(2))
                0: w.normal_x = unit;
                1: w.normal_y = unit;
                default: w.normal_z = unit;
            endcase
            w.plane_offset = 24'(int'($urandom_range(8192)) - 4096);
        end
        return w;
    endfunction

    function automatic cmd_word_t point_word();
        cmd_word_t w;
        w = noise_word();
        w.action = ACT_LOCATE;
        if ($urandom_range(9) < 3)
        begin
            w.point_x = 24'(int'($urandom_range(8192)) - 4096);
            w.point_y = 24'(int'($urandom_range(8192)) - 4096);
            w.point_z = 24'(int'($urandom_range(8192)) - 4096);
        end
        return w;
    endfunction

    task automatic send_word(input cmd_word_t w);
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd <= w;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cmd_ready);
        tracker.take_cmd(w);
        words_sent++;
    endtask

    // Writes any entry the walk would touch before it is ever read.
    task automatic locate_with_fill(input cmd_word_t w);
        status_t     st;
        logic [14:0] lf;
        int          mn;
        int          mp;
        bit          clear;
        clear = 1'b0;
        while (!clear)
        begin
            st = tracker.trace_leaf(w.point_x, w.point_y, w.point_z, lf, mn, mp);
            if (mn >= 0)
                send_word(node_word(mn));
            else if (mp >= 0)
                send_word(plane_word(mp));
            else
                clear = 1'b1;
        end
        send_word(w);
    endtask

    task automatic hold_until_drained();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.outstanding() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        tracker.set_reg(idx, val);
    endtask

    task automatic set_regs(int root, int nodes, int leaves);
        write_reg(CFG_SPARE, 16'($urandom));
        write_reg(CFG_ROOT_NODE, 16'(root));
        write_reg(CFG_NODE_COUNT, 16'(nodes));
        write_reg(CFG_LEAF_COUNT, 16'(leaves));
        cfg_we <= 1'b0;
    endtask

    task automatic set_mode(int m);
        case (m)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 69; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 69; end
            default: begin idle_pct = 13; stall_pct = 13; end
        endcase
    endtask

    task automatic run_directed();
        cmd_word_t w;
        set_mode(0);
        // node_count is 0 after reset, so root 0 is out of range
        w = blank_word(ACT_LOCATE);
        w.point_x = 24'sh7FFFFF;
        w.point_y = 24'sh800000;
        w.point_z = 24'sh7FFFFF;
        send_word(w);
        w = '1;
        send_word(w);
        w = blank_word(ACT_WR_NODE);
        w.slot = 12'd4095;
        w.node_plane = 12'd4095;
        w.front_child = 16'sh8000;
        w.back_child = 16'sh7FFF;
        send_word(w);
        w = blank_word(ACT_WR_PLANE);
        w.slot = 12'd4095;
        w.normal_x = 16'sh8000;
        w.normal_y = 16'sh7FFF;
        w.plane_offset = 24'sh800000;
        send_word(w);
        // node 0: plane x = 1.0, leaf 0 in front, leaf 1 behind
        w = blank_word(ACT_WR_NODE);
        w.front_child = -16'sd1;
        w.back_child = -16'sd2;
        send_word(w);
        w = blank_word(ACT_WR_PLANE);
        w.normal_x = 16'sd16384;
        w.plane_offset = 24'sd256;
        send_word(w);
        // node 1 points at itself on a null plane
        w = blank_word(ACT_WR_NODE);
        w.slot = 12'd1;
        w.node_plane = 12'd1;
        w.front_child = 16'sd1;
        w.back_child = 16'sd1;
        send_word(w);
        w = blank_word(ACT_WR_PLANE);
        w.slot = 12'd1;
        send_word(w);

        hold_until_drained();
        set_regs(0, NODE_SLOTS, 32768);
        w = blank_word(ACT_LOCATE);
        w.point_x = 24'sd256;
        send_word(w);
        w.point_x = 24'sd255;
        send_word(w);
        w.point_x = 24'sh7FFFFF;
        w.point_y = 24'sh800000;
        w.point_z = 24'sh800000;
        send_word(w);
        w.point_x = 24'sh800000;
        send_word(w);

        hold_until_drained();
        set_regs(NODE_SLOTS - 1, NODE_SLOTS, 32768);
        w = blank_word(ACT_LOCATE);
        send_word(w);
        w.point_x = 24'sh7FFFFF;
        w.point_y = 24'sh800000;
        send_word(w);

        hold_until_drained();
        set_regs(1, NODE_SLOTS, 32768);
        send_word(point_word());

        hold_until_drained();
        set_regs(0, NODE_SLOTS, 1);
        w = blank_word(ACT_LOCATE);
        send_word(w);
        w.point_x = 24'sd256;
        send_word(w);

        hold_until_drained();
        set_regs(-1, NODE_SLOTS, 32768);
        send_word(point_word());

        hold_until_drained();
        set_regs(5, 5, 8);
        send_word(point_word());
    endtask

    task automatic run_random_phase(int idx);
        int        r;
        int        root;
        int        ncnt;
        int        lcnt;
        int        len;
        cmd_word_t w;
        hold_until_drained();
        span_nodes = ($urandom_range(9) < 7) ? $urandom_range(128, 16)
                                              : $urandom_range(600, 200);
        span_planes = $urandom_range(span_nodes, 4);
        r = $urandom_range(99);
        ncnt = (r < 60) ? span_nodes : (r < 80) ? $urandom_range(span_nodes, 1) : NODE_SLOTS;
        r = $urandom_range(99);
        if (r < 85)
            root = $urandom_range(span_nodes / 4);
        else if (r < 92)
            root = -1;
        else if (r < 96)
            root = NODE_SLOTS - 1;
        else
            root = $urandom_range(NODE_SLOTS - 1);
        r = $urandom_range(99);
        if (r < 40)
            lcnt = $urandom_range(64, 1);
        else if (r < 70)
            lcnt = 32768;
        else if (r < 85)
            lcnt = 0;
        else
            lcnt = $urandom_range(32768);
        set_regs(root, ncnt, lcnt);
        set_mode(idx % 4);
        len = 200;
        for (int n = 0; n < len; n++)
        begin
            if (n == len / 2)
                hold_until_drained();
            r = $urandom_range(99);
            if (r < 55)
                locate_with_fill(point_word());
            else if (r < 75)
                send_word(node_word($urandom_range(span_nodes - 1)));
            else if (r < 88)
                send_word(plane_word($urandom_range(span_planes - 1)));
            else if (r < 92)
                send_word(node_word($urandom_range(NODE_SLOTS - 1)));
            else if (r < 96)
                send_word(plane_word($urandom_range(PLANE_SLOTS - 1)));
            else
            begin
                w = noise_word();
                w.action = ACT_NONE;
                send_word(w);
            end
        end
    endtask

    initial
    begin
        int phase_no;
        phase_no = 0;
        tracker = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        while (words_sent < ITEM_GOAL)
        begin
            run_random_phase(phase_no);
            phase_no++;
        end
        hold_until_drained();
        repeat (40) @(posedge clk);
        if (tracker.fails == 0 && tracker.outstanding() == 0)
            $display("bsp_point_leaf_locate_core: match");
        else
            $display("bsp_point_leaf_locate_core: mismatch");
        $finish;
    end

endmodule
